// File: rtl/ccfg_pkg.sv
// ccfg_pkg: shared types and constants for the coulomb counter fuel gauge core
// used by ccfg_mul, ccfg_div, ccfg_tbl and coulomb_counter_fuel_gauge_core
// no dependencies
package ccfg_pkg;

  // shared multiplier operand and product widths
  localparam int MUL_A_W = 34;
  localparam int MUL_B_W = 16;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // divisor width of the shared divider, holds the read scaling divisor
  localparam int DIVR_W = 22;

  // result width of the percent
  localparam int PCT_W = 11;

  // arithmetic constants
  localparam int MILLI_SCALE  = 1000;
  localparam int PCT_SCALE    = 100;
  localparam int READ_SCALE   = 1250;
  // 20 * 32768 * 36 / 10, worked out at elaboration
  localparam int READ_DIVISOR = 20 * 32768 * 36 / 10;

  localparam logic [15:0] FULL_RESET = 16'd2000;

  localparam logic signed [PCT_W-1:0] PCT_MAX = 11'sh3FF;
  localparam logic signed [PCT_W-1:0] PCT_MIN = 11'sh400;

  // configuration register indexes
  localparam logic [1:0] CFG_FULL_CHARGE = 2'd0;
  localparam logic [1:0] CFG_PACK_RES    = 2'd1;
  localparam logic [1:0] CFG_TBL_ENTRIES = 2'd2;

  typedef enum logic [2:0] {
    CMD_TABLE_WRITE = 3'd0,
    CMD_INIT        = 3'd1,
    CMD_CAL_RESULT  = 3'd2,
    CMD_READ        = 3'd3,
    CMD_RECAL       = 3'd4,
    CMD_CHARGE_DONE = 3'd5
  } cmd_e;

  typedef struct packed {
    logic [6:0]  pct;
    logic [12:0] mv;
  } tbl_entry_t;

  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] dividend;
    logic [DIVR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] quotient;
  } div_rsp_t;

endpackage

// File: rtl/ccfg_mul.sv
// ccfg_mul: shared unsigned multiplier with a registered product
// depends on ccfg_pkg
module ccfg_mul import ccfg_pkg::*; (
  input  logic               clk_i,
  input  logic [MUL_A_W-1:0] a_i,
  input  logic [MUL_B_W-1:0] b_i,
  output logic [PROD_W-1:0]  prod_o
);

  logic [PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign prod_o = prod_q;

endmodule

// File: rtl/ccfg_div.sv
// ccfg_div: shared restoring divider, one quotient bit per cycle
// depends on ccfg_pkg
module ccfg_div import ccfg_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int CW = $clog2(PROD_W + 1);

  logic              busy_q;
  logic              done_q;
  logic [CW-1:0]     cnt_q;
  logic [DIVR_W-1:0] rem_q;
  logic [DIVR_W-1:0] dvs_q;
  logic [PROD_W-1:0] quo_q;
  logic [DIVR_W:0]   trial;
  logic [DIVR_W:0]   trial_sub;
  logic              fits;

  // shift the next dividend bit into the partial remainder
  assign trial     = {rem_q, quo_q[PROD_W-1]};
  assign trial_sub = trial - {1'b0, dvs_q};
  assign fits      = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(PROD_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // quotient bits replace dividend bits as they shift out
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      dvs_q <= req_i.divisor;
      quo_q <= req_i.dividend;
    end else if (busy_q) begin
      rem_q <= fits ? trial_sub[DIVR_W-1:0] : trial[DIVR_W-1:0];
      quo_q <= {quo_q[PROD_W-2:0], fits};
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// File: rtl/ccfg_tbl.sv
// ccfg_tbl: voltage to percent table memory, one write and one registered read port
// depends on ccfg_pkg
module ccfg_tbl import ccfg_pkg::*; #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [$clog2(TABLE_DEPTH)-1:0] waddr_i,
  input  tbl_entry_t                     wdata_i,
  input  logic [$clog2(TABLE_DEPTH)-1:0] raddr_i,
  output tbl_entry_t                     rdata_o
);

  tbl_entry_t mem_q [TABLE_DEPTH];
  tbl_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/coulomb_counter_fuel_gauge_core.sv
// coulomb_counter_fuel_gauge_core: top level of the coulomb counting fuel gauge
// depends on ccfg_pkg, ccfg_mul, ccfg_div, ccfg_tbl
//
// The core takes one gauge command per input transfer and returns exactly one result
// transfer (capacity percent and status) for it. A small sequencer drives one shared
// registered multiplier and one shared restoring divider that yields one quotient bit a
// cycle over a 50-bit dividend; that divider sets the pace. Table write, cal result,
// charge done and unknown commands go straight to the result state. Init divides for
// the ir drop, scans the entries, each read and then compared as the table read is
// registered, and makes a second divider pass for the start charge. Read and recal run
// two divider passes, recal a third one to rescale the start charge. in_ready_o is high
// only while no command is in work; a finished result sits in an output register, so the
// next command is taken while the previous result still waits for out_ready_i.
// Configuration writes are taken at any time but belong in idle periods.
module coulomb_counter_fuel_gauge_core import ccfg_pkg::*; #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // configuration write port
  input  logic                    cfg_we_i,
  input  logic [1:0]              cfg_idx_i,
  input  logic [15:0]             cfg_wdata_i,
  // command channel
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [2:0]              command_i,
  input  logic [3:0]              table_index_i,
  input  logic [6:0]              entry_percent_i,
  input  logic [12:0]             entry_mv_i,
  input  logic [12:0]             voltage_mv_i,
  input  logic signed [13:0]      current_ma_i,
  input  logic [23:0]             sample_count_i,
  input  logic signed [31:0]      accumulator_i,
  input  logic [8:0]              offset_magnitude_i,
  input  logic                    offset_negative_i,
  // result channel
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [PCT_W-1:0] capacity_percent_o,
  output logic                    status_o
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int NW = $clog2(TABLE_DEPTH + 1);

  // one-hot sequencer states
  typedef enum logic [17:0] {
    ST_IDLE      = 18'h00001,
    ST_INIT_MUL  = 18'h00002,
    ST_INIT_DIV  = 18'h00004,
    ST_INIT_WAIT = 18'h00008,
    ST_SCAN_RD   = 18'h00010,
    ST_SCAN_CMP  = 18'h00020,
    ST_PCT_MUL   = 18'h00040,
    ST_PCT_DIV   = 18'h00080,
    ST_PCT_WAIT  = 18'h00100,
    ST_RD_MUL1   = 18'h00200,
    ST_RD_SUB    = 18'h00400,
    ST_RD_MUL2   = 18'h00800,
    ST_RD_DIV1   = 18'h01000,
    ST_RD_WAIT1  = 18'h02000,
    ST_RD_MUL3   = 18'h04000,
    ST_RD_DIV2   = 18'h08000,
    ST_RD_WAIT2  = 18'h10000,
    ST_FIN       = 18'h20000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [15:0] full_q;
  logic [9:0]  pack_res_q;
  logic [4:0]  entries_q;

  // gauge state
  logic signed [31:0] start_q, start_d;
  logic signed [9:0]  offset_q, offset_d;

  // command fields held while the command is in work
  cmd_e               cmd_q;
  logic [12:0]        volt_q;
  logic [13:0]        cur_mag_q;
  logic               cur_neg_q;
  logic [23:0]        cnt_q;
  logic signed [31:0] acc_q;

  // working registers
  logic [MUL_A_W-1:0]      mag_q, mag_d;
  logic                    sign_q, sign_d;
  logic signed [15:0]      mv_q, mv_d;
  logic [NW-1:0]           scan_q, scan_d;
  logic signed [PCT_W-1:0] pct_q, pct_d;
  logic signed [PCT_W-1:0] res_pct_q, res_pct_d;
  logic                    res_status_q, res_status_d;

  // output register
  logic                    out_valid_q;
  logic signed [PCT_W-1:0] out_pct_q;
  logic                    out_status_q;
  logic                    out_load;

  // shared units
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  mul_p;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  // table port
  logic                 tbl_we;
  logic [AW-1:0]        tbl_raddr;
  tbl_entry_t           tbl_wdata;
  tbl_entry_t           tbl_rdata;
  logic [NW-1:0]        scan_m1;
  logic                 idx_ok;
  logic [31:0]          ent_ext;
  logic [NW-1:0]        scan_n;

  // helper arithmetic
  logic                    in_acc;
  logic [13:0]             cur_u;
  logic signed [9:0]       off_in;
  logic [9:0]              off_u;
  logic [9:0]              off_mag;
  logic [PCT_W-1:0]        pct_u;
  logic [PCT_W-1:0]        pct_mag;
  logic [15:0]             drop_q16;
  logic signed [15:0]      drop_s;
  logic signed [15:0]      mv_calc;
  logic signed [35:0]      offprod_s;
  logic signed [35:0]      diff_s;
  logic [35:0]             diff_u;
  logic [35:0]             diff_mag;
  logic signed [33:0]      iacc_s;
  logic signed [33:0]      cc_s;
  logic [33:0]             cc_u;
  logic [33:0]             cc_mag;
  logic [31:0]             q32;
  logic                    q_over_pos;
  logic                    q_over_neg;
  logic signed [PCT_W-1:0] pct_sat;
  logic [DIVR_W-1:0]       full_div;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i & in_ready_o;

  // table index check and scan length
  assign idx_ok    = 32'(table_index_i) < 32'(TABLE_DEPTH);
  assign ent_ext   = 32'(entries_q);
  assign scan_n    = (ent_ext > 32'(TABLE_DEPTH)) ? NW'(TABLE_DEPTH) : NW'(ent_ext);
  assign scan_m1   = scan_q - NW'(1);
  assign tbl_raddr = scan_m1[AW-1:0];
  assign tbl_wdata = '{pct: entry_percent_i, mv: entry_mv_i};

  // sign-magnitude helpers
  assign cur_u   = $unsigned(current_ma_i);
  assign off_in  = $signed({1'b0, offset_magnitude_i});
  assign off_u   = $unsigned(offset_q);
  assign off_mag = offset_q[9] ? (~off_u + 10'd1) : off_u;
  assign pct_u   = $unsigned(pct_q);
  assign pct_mag = pct_q[PCT_W-1] ? (~pct_u + 11'd1) : pct_u;

  // ir drop: r * |i| / 1000 with the sign of the current
  assign drop_q16 = div_rsp.quotient[15:0];
  assign drop_s   = cur_neg_q ? -$signed(drop_q16) : $signed(drop_q16);
  assign mv_calc  = $signed({3'b000, volt_q}) - drop_s;

  // accumulator minus offset times sample count
  assign offprod_s = offset_q[9] ? -$signed({2'b00, mul_p[33:0]})
                                 : $signed({2'b00, mul_p[33:0]});
  assign diff_s    = $signed({{4{acc_q[31]}}, acc_q}) - offprod_s;
  assign diff_u    = $unsigned(diff_s);
  assign diff_mag  = diff_s[35] ? (~diff_u + 36'd1) : diff_u;

  // charge in mah: start charge plus the scaled accumulator
  assign iacc_s = sign_q ? -$signed(div_rsp.quotient[33:0])
                         : $signed(div_rsp.quotient[33:0]);
  assign cc_s   = $signed({{2{start_q[31]}}, start_q}) + iacc_s;
  assign cc_u   = $unsigned(cc_s);
  assign cc_mag = cc_s[33] ? (~cc_u + 34'd1) : cc_u;

  // percent saturation on the quotient magnitude
  assign q_over_pos = (|div_rsp.quotient[PROD_W-1:PCT_W-1]);
  assign q_over_neg = (|div_rsp.quotient[PROD_W-1:PCT_W]) |
                      (div_rsp.quotient[PCT_W-1] & (|div_rsp.quotient[PCT_W-2:0]));
  always_comb begin
    if (sign_q) begin
      pct_sat = q_over_neg ? PCT_MIN : -$signed(div_rsp.quotient[PCT_W-1:0]);
    end else begin
      pct_sat = q_over_pos ? PCT_MAX : $signed(div_rsp.quotient[PCT_W-1:0]);
    end
  end

  assign q32      = div_rsp.quotient[31:0];
  // a zero full capacity divides as one
  assign full_div = (full_q == '0) ? DIVR_W'(1) : DIVR_W'(full_q);

  // sequencer
  always_comb begin
    state_d      = state_q;
    start_d      = start_q;
    offset_d     = offset_q;
    mag_d        = mag_q;
    sign_d       = sign_q;
    mv_d         = mv_q;
    scan_d       = scan_q;
    pct_d        = pct_q;
    res_pct_d    = res_pct_q;
    res_status_d = res_status_q;
    tbl_we       = 1'b0;
    mul_a        = '0;
    mul_b        = '0;
    div_req          = '0;
    div_req.dividend = mul_p;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          res_pct_d    = '0;
          res_status_d = 1'b0;
          state_d      = ST_FIN;
          unique case (cmd_e'(command_i))
            CMD_TABLE_WRITE: begin
              if (idx_ok) begin
                tbl_we = 1'b1;
              end else begin
                res_status_d = 1'b1;
              end
            end
            CMD_INIT: begin
              // zero current is rejected with no state change
              if (current_ma_i == '0) begin
                res_status_d = 1'b1;
              end else begin
                state_d = ST_INIT_MUL;
              end
            end
            CMD_CAL_RESULT: begin
              offset_d = offset_negative_i ? -off_in : off_in;
            end
            CMD_READ, CMD_RECAL: begin
              state_d = ST_RD_MUL1;
            end
            CMD_CHARGE_DONE: begin
              start_d  = $signed(32'(full_q));
              offset_d = '0;
            end
            default: begin
              // unknown command, result is zero with ok status
            end
          endcase
        end
      end

      // init: compensate voltage, scan table, set start charge
      ST_INIT_MUL: begin
        mul_a   = MUL_A_W'(cur_mag_q);
        mul_b   = MUL_B_W'(pack_res_q);
        state_d = ST_INIT_DIV;
      end
      ST_INIT_DIV: begin
        div_req.start   = 1'b1;
        div_req.divisor = DIVR_W'(MILLI_SCALE);
        state_d         = ST_INIT_WAIT;
      end
      ST_INIT_WAIT: begin
        if (div_rsp.done) begin
          mv_d  = mv_calc;
          pct_d = '0;
          if (scan_n == '0) begin
            state_d = ST_PCT_MUL;
          end else begin
            scan_d  = scan_n;
            state_d = ST_SCAN_RD;
          end
        end
      end
      ST_SCAN_RD: begin
        state_d = ST_SCAN_CMP;
      end
      ST_SCAN_CMP: begin
        // last entry first, first threshold above the voltage wins
        if (mv_q < $signed({3'b000, tbl_rdata.mv})) begin
          pct_d   = $signed({4'b0000, tbl_rdata.pct});
          state_d = ST_PCT_MUL;
        end else if (scan_q == NW'(1)) begin
          pct_d   = '0;
          state_d = ST_PCT_MUL;
        end else begin
          scan_d  = scan_m1;
          state_d = ST_SCAN_RD;
        end
      end

      // start charge = full * percent / 100, shared by init and recal
      ST_PCT_MUL: begin
        mul_a   = MUL_A_W'(pct_mag);
        mul_b   = full_q;
        state_d = ST_PCT_DIV;
      end
      ST_PCT_DIV: begin
        div_req.start   = 1'b1;
        div_req.divisor = DIVR_W'(PCT_SCALE);
        state_d         = ST_PCT_WAIT;
      end
      ST_PCT_WAIT: begin
        if (div_rsp.done) begin
          start_d   = pct_q[PCT_W-1] ? -$signed(q32) : $signed(q32);
          res_pct_d = pct_q;
          state_d   = ST_FIN;
        end
      end

      // read: offset correction, scaling to mah, percent of full
      ST_RD_MUL1: begin
        mul_a   = MUL_A_W'(cnt_q);
        mul_b   = MUL_B_W'(off_mag);
        state_d = ST_RD_SUB;
      end
      ST_RD_SUB: begin
        mag_d   = diff_mag[MUL_A_W-1:0];
        sign_d  = diff_s[35];
        state_d = ST_RD_MUL2;
      end
      ST_RD_MUL2: begin
        mul_a   = mag_q;
        mul_b   = MUL_B_W'(READ_SCALE);
        state_d = ST_RD_DIV1;
      end
      ST_RD_DIV1: begin
        div_req.start   = 1'b1;
        div_req.divisor = DIVR_W'(READ_DIVISOR);
        state_d         = ST_RD_WAIT1;
      end
      ST_RD_WAIT1: begin
        if (div_rsp.done) begin
          mag_d   = cc_mag;
          sign_d  = cc_s[33];
          state_d = ST_RD_MUL3;
        end
      end
      ST_RD_MUL3: begin
        mul_a   = mag_q;
        mul_b   = MUL_B_W'(PCT_SCALE);
        state_d = ST_RD_DIV2;
      end
      ST_RD_DIV2: begin
        div_req.start   = 1'b1;
        div_req.divisor = full_div;
        state_d         = ST_RD_WAIT2;
      end
      ST_RD_WAIT2: begin
        if (div_rsp.done) begin
          pct_d = pct_sat;
          if (cmd_q == CMD_RECAL) begin
            offset_d = '0;
            state_d  = ST_PCT_MUL;
          end else begin
            res_pct_d = pct_sat;
            state_d   = ST_FIN;
          end
        end
      end

      // hand the result over once the output register is free
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_load = (state_q == ST_FIN) && (!out_valid_q || out_ready_i);

  // control state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      start_q     <= '0;
      offset_q    <= '0;
      full_q      <= FULL_RESET;
      pack_res_q  <= '0;
      entries_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      start_q     <= start_d;
      offset_q    <= offset_d;
      out_valid_q <= out_load | (out_valid_q & ~out_ready_i);
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_FULL_CHARGE: full_q     <= cfg_wdata_i;
          CFG_PACK_RES:    pack_res_q <= cfg_wdata_i[9:0];
          CFG_TBL_ENTRIES: entries_q  <= cfg_wdata_i[4:0];
          default: begin
            // writes beyond the register list are dropped
          end
        endcase
      end
    end
  end

  // payload and working registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q     <= cmd_e'(command_i);
      volt_q    <= voltage_mv_i;
      cur_neg_q <= current_ma_i[13];
      cur_mag_q <= current_ma_i[13] ? (~cur_u + 14'd1) : cur_u;
      cnt_q     <= sample_count_i;
      acc_q     <= accumulator_i;
    end
    mag_q        <= mag_d;
    sign_q       <= sign_d;
    mv_q         <= mv_d;
    scan_q       <= scan_d;
    pct_q        <= pct_d;
    res_pct_q    <= res_pct_d;
    res_status_q <= res_status_d;
    if (out_load) begin
      out_pct_q    <= res_pct_q;
      out_status_q <= res_status_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign capacity_percent_o = out_pct_q;
  assign status_o           = out_status_q;

  ccfg_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (mul_p)
  );

  ccfg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  ccfg_tbl #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_tbl (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (AW'(table_index_i)),
    .wdata_i (tbl_wdata),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

endmodule

// File: test/tb_coulomb_counter_fuel_gauge_core.sv
`timescale 1ns / 1ps
// tb_coulomb_counter_fuel_gauge_core: self-checking testbench for the fuel gauge core
// depends on ccfg_pkg and coulomb_counter_fuel_gauge_core; results are predicted in-line
module tb_coulomb_counter_fuel_gauge_core;
  import ccfg_pkg::*;

  localparam int GAUGE_DEPTH = 16;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int PHASE_ITEMS = 175;
  localparam int NUM_PHASES  = 6;
  // commands outside the defined set, the core must answer them with a plain ok
  localparam logic [2:0] CMD_RSVD_6 = 3'd6;
  localparam logic [2:0] CMD_RSVD_7 = 3'd7;

  // one gauge command as it crosses the input channel
  typedef struct {
    logic [2:0]         command;
    logic [3:0]         table_index;
    logic [6:0]         entry_percent;
    logic [12:0]        entry_mv;
    logic [12:0]        voltage_mv;
    logic signed [13:0] current_ma;
    logic [23:0]        sample_count;
    logic signed [31:0] accumulator;
    logic [8:0]         offset_magnitude;
    logic               offset_negative;
  } gauge_cmd_t;

  // one result transfer
  typedef struct {
    logic signed [PCT_W-1:0] capacity_percent;
    logic                    status;
  } gauge_res_t;

  // clock, reset and every block input start at known values
  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we_i = 1'b0;
  logic [1:0]              cfg_idx_i = '0;
  logic [15:0]             cfg_wdata_i = '0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic [2:0]              command_i = '0;
  logic [3:0]              table_index_i = '0;
  logic [6:0]              entry_percent_i = '0;
  logic [12:0]             entry_mv_i = '0;
  logic [12:0]             voltage_mv_i = '0;
  logic signed [13:0]      current_ma_i = '0;
  logic [23:0]             sample_count_i = '0;
  logic signed [31:0]      accumulator_i = '0;
  logic [8:0]              offset_magnitude_i = '0;
  logic                    offset_negative_i = 1'b0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic signed [PCT_W-1:0] capacity_percent_o;
  logic                    status_o;

  // gauge state as the predictor sees it
  logic [6:0]  gauge_pct_tbl [GAUGE_DEPTH];
  logic [12:0] gauge_mv_tbl [GAUGE_DEPTH];
  bit          gauge_tbl_loaded [GAUGE_DEPTH];
  int          charge_base_mah = 0;
  int          cal_offset = 0;
  logic [15:0] cfg_full_mah = FULL_RESET;
  logic [9:0]  cfg_pack_mohm = '0;
  logic [4:0]  cfg_entries = '0;

  // results still owed by the core, oldest first
  gauge_res_t gauge_result_q [$];

  int err_cnt = 0;
  int cycle_cnt = 0;
  int rx_hold = 0;
  bit idle_en = 1'b1;

  coulomb_counter_fuel_gauge_core #(
    .TABLE_DEPTH(GAUGE_DEPTH)
  ) dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .command_i         (command_i),
    .table_index_i     (table_index_i),
    .entry_percent_i   (entry_percent_i),
    .entry_mv_i        (entry_mv_i),
    .voltage_mv_i      (voltage_mv_i),
    .current_ma_i      (current_ma_i),
    .sample_count_i    (sample_count_i),
    .accumulator_i     (accumulator_i),
    .offset_magnitude_i(offset_magnitude_i),
    .offset_negative_i (offset_negative_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .capacity_percent_o(capacity_percent_o),
    .status_o          (status_o)
  );

  always #10 clk_i = ~clk_i;

  // watchdog on the whole run
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // read percent: offset-corrected accumulator scaled to mAh, plus the base charge,
  // over the full capacity, saturated to the 11-bit range
  function automatic longint read_pct(gauge_cmd_t it);
    longint diff, cc, pct, full_div;
    diff = longint'(it.accumulator) - longint'(cal_offset) * longint'(it.sample_count);
    cc = longint'(charge_base_mah) + diff * READ_SCALE / READ_DIVISOR;
    // zero capacity divides as one
    full_div = (cfg_full_mah == '0) ? 64'sd1 : longint'(cfg_full_mah);
    pct = cc * PCT_SCALE / full_div;
    if (pct > longint'(PCT_MAX)) pct = PCT_MAX;
    if (pct < longint'(PCT_MIN)) pct = PCT_MIN;
    return pct;
  endfunction

  // expected result of one accepted command, state updated along the way
  function automatic gauge_res_t predict_gauge(gauge_cmd_t it);
    gauge_res_t res;
    longint pct, comp_mv, cur;
    int scan_n, i;
    bit hit;
    pct = 0;
    hit = 1'b0;
    res.status = 1'b0;
    case (it.command)
      CMD_TABLE_WRITE: begin
        // index is 4 bits, so it never reaches past the table
        gauge_pct_tbl[it.table_index] = it.entry_percent;
        gauge_mv_tbl[it.table_index] = it.entry_mv;
        gauge_tbl_loaded[it.table_index] = 1'b1;
      end
      CMD_INIT: begin
        cur = longint'(it.current_ma);
        if (cur == 0) begin
          // zero current is rejected and leaves the state alone
          res.status = 1'b1;
        end else begin
          // ir drop compensation, then scan from the last valid entry down
          comp_mv = longint'(it.voltage_mv) - longint'(cfg_pack_mohm) * cur / MILLI_SCALE;
          scan_n = (cfg_entries > GAUGE_DEPTH) ? GAUGE_DEPTH : int'(cfg_entries);
          for (i = scan_n - 1; i >= 0 && !hit; i--) begin
            if (!gauge_tbl_loaded[i]) begin
              $error("stimulus scans table entry %0d before it was loaded", i);
              err_cnt++;
            end
            if (comp_mv < longint'(gauge_mv_tbl[i])) begin
              pct = gauge_pct_tbl[i];
              hit = 1'b1;
            end
          end
          charge_base_mah = int'(longint'(cfg_full_mah) * pct / PCT_SCALE);
        end
      end
      CMD_CAL_RESULT: begin
        cal_offset = it.offset_negative ? -int'(it.offset_magnitude)
                                        : int'(it.offset_magnitude);
      end
      CMD_READ: pct = read_pct(it);
      CMD_RECAL: begin
        pct = read_pct(it);
        charge_base_mah = int'(longint'(cfg_full_mah) * pct / PCT_SCALE);
        cal_offset = 0;
      end
      CMD_CHARGE_DONE: begin
        charge_base_mah = int'(cfg_full_mah);
        cal_offset = 0;
      end
      default: ;
    endcase
    res.capacity_percent = pct[PCT_W-1:0];
    return res;
  endfunction

  // result side: random ready stalls, and every result transfer checked in order
  always @(posedge clk_i) begin : result_check
    gauge_res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (gauge_result_q.size() == 0) begin
        $error("unexpected result transfer: capacity_percent %0d status %0d",
               capacity_percent_o, status_o);
        err_cnt++;
      end else begin
        want = gauge_result_q.pop_front();
        if (capacity_percent_o !== want.capacity_percent) begin
          $error("capacity_percent mismatch: expected %0d, got %0d",
                 want.capacity_percent, capacity_percent_o);
          err_cnt++;
        end
        if (status_o !== want.status) begin
          $error("status mismatch: expected %0d, got %0d", want.status, status_o);
          err_cnt++;
        end
      end
    end
    // ready holds its value for a random stretch and is sometimes driven low
    if (rx_hold > 0) begin
      rx_hold--;
    end else if (idle_en && $urandom_range(0, 3) == 0) begin
      out_ready_i <= 1'b0;
      rx_hold = $urandom_range(0, 14);
    end else begin
      out_ready_i <= 1'b1;
      rx_hold = $urandom_range(0, 19);
    end
  end

  // one command transfer; valid stays up between back-to-back commands
  task automatic send_item(input gauge_cmd_t it);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_valid_i         <= 1'b1;
    command_i          <= it.command;
    table_index_i      <= it.table_index;
    entry_percent_i    <= it.entry_percent;
    entry_mv_i         <= it.entry_mv;
    voltage_mv_i       <= it.voltage_mv;
    current_ma_i       <= it.current_ma;
    sample_count_i     <= it.sample_count;
    accumulator_i      <= it.accumulator;
    offset_magnitude_i <= it.offset_magnitude;
    offset_negative_i  <= it.offset_negative;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    gauge_result_q.push_back(predict_gauge(it));
  endtask

  // let every owed result come back, so the core is idle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (gauge_result_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_FULL_CHARGE: cfg_full_mah = data;
      CFG_PACK_RES:    cfg_pack_mohm = data[9:0];
      CFG_TBL_ENTRIES: cfg_entries = data[4:0];
      default: ;
    endcase
  endtask

  // all three registers, only ever called on an idle core
  task automatic apply_config(input logic [15:0] full_mah, input logic [9:0] pack_mohm,
                              input logic [4:0] entries);
    write_reg(CFG_FULL_CHARGE, full_mah);
    write_reg(CFG_PACK_RES, {6'd0, pack_mohm});
    write_reg(CFG_TBL_ENTRIES, {11'd0, entries});
    cfg_we_i <= 1'b0;
  endtask

  // every field random, so fields a command ignores still toggle
  function automatic gauge_cmd_t noise_item();
    gauge_cmd_t it;
    it.command          = CMD_READ;
    it.table_index      = 4'($urandom);
    it.entry_percent    = 7'($urandom_range(0, 100));
    it.entry_mv         = 13'($urandom);
    it.voltage_mv       = 13'($urandom);
    it.current_ma       = 14'($urandom);
    it.sample_count     = 24'($urandom);
    it.accumulator      = $urandom;
    it.offset_magnitude = 9'($urandom);
    it.offset_negative  = 1'($urandom);
    return it;
  endfunction

  // random command mix; reads mostly land inside the percent range
  function automatic gauge_cmd_t random_item();
    gauge_cmd_t it;
    int pick;
    it = noise_item();
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      it.command = CMD_TABLE_WRITE;
    end else if (pick < 34) begin
      it.command = CMD_INIT;
      if ($urandom_range(0, 9) == 0) it.current_ma = '0;
      else if (it.current_ma == 0) it.current_ma = 14'sd1;
    end else if (pick < 46) begin
      it.command = CMD_CAL_RESULT;
    end else if (pick < 88) begin
      it.command = (pick < 76) ? CMD_READ : CMD_RECAL;
      // small accumulator and sample count keep the percent out of saturation
      if ($urandom_range(0, 3) != 0)
        it.accumulator = int'($urandom_range(0, 32'd67108864)) - 32'sd33554432;
      if ($urandom_range(0, 7) != 0) it.sample_count = 24'($urandom_range(0, 4095));
    end else if (pick < 96) begin
      it.command = CMD_CHARGE_DONE;
    end else begin
      it.command = pick[0] ? CMD_RSVD_7 : CMD_RSVD_6;
    end
    return it;
  endfunction

  // reset state: read gives zero, init with an empty table finds nothing
  task automatic test_reset_state();
    gauge_cmd_t it;
    it = noise_item();
    it.command      = CMD_READ;
    it.accumulator  = '0;
    it.sample_count = '0;
    send_item(it);
    it = noise_item();
    it.command    = CMD_INIT;
    it.current_ma = 14'sd1;
    send_item(it);
  endtask

  // a few entries with extreme thresholds and percents, then four of them in use
  task automatic test_table_load();
    gauge_cmd_t it;
    int idx [5] = '{0, 1, 2, 3, 15};
    int pct [5] = '{100, 60, 20, 0, 5};
    int mv [5]  = '{8191, 3700, 3400, 0, 100};
    for (int k = 0; k < 5; k++) begin
      it = noise_item();
      it.command       = CMD_TABLE_WRITE;
      it.table_index   = 4'(idx[k]);
      it.entry_percent = 7'(pct[k]);
      it.entry_mv      = 13'(mv[k]);
      send_item(it);
    end
    drain();
    apply_config(FULL_RESET, 10'd1023, 5'd4);
  endtask

  // scan hits in the middle, no hit, negative compensated voltage, zero current
  task automatic test_init_scan();
    gauge_cmd_t it;
    int volts [5] = '{3500, 0, 8191, 4000, 3000};
    int amps [5]  = '{1, -8192, 8191, 0, 2};
    for (int k = 0; k < 5; k++) begin
      it = noise_item();
      it.command    = CMD_INIT;
      it.voltage_mv = 13'(volts[k]);
      it.current_ma = 14'(amps[k]);
      send_item(it);
    end
  endtask

  // sign-magnitude offset, saturation at both ends, then an unsaturated read
  task automatic test_offset_read();
    gauge_cmd_t it;
    it = noise_item();
    it.command          = CMD_CAL_RESULT;
    it.offset_magnitude = 9'd511;
    it.offset_negative  = 1'b1;
    send_item(it);
    it = noise_item();
    it.command      = CMD_READ;
    it.accumulator  = '0;
    it.sample_count = 24'hFFFFFF;
    send_item(it);
    it.accumulator  = 32'sh8000_0000;
    it.sample_count = '0;
    send_item(it);
    it.accumulator  = 32'sh7FFF_FFFF;
    send_item(it);
    it = noise_item();
    it.command          = CMD_CAL_RESULT;
    it.offset_magnitude = 9'd300;
    it.offset_negative  = 1'b0;
    send_item(it);
    it = noise_item();
    it.command      = CMD_READ;
    it.accumulator  = 32'sd2000000;
    it.sample_count = 24'd1000;
    send_item(it);
  endtask

  // recal to a negative charge, then charge done back to full
  task automatic test_recal_charge();
    gauge_cmd_t it;
    it = noise_item();
    it.command      = CMD_RECAL;
    it.accumulator  = -32'sd3000000;
    it.sample_count = 24'd100;
    send_item(it);
    it.command      = CMD_READ;
    it.accumulator  = '0;
    it.sample_count = 24'd500;
    send_item(it);
    it = noise_item();
    it.command = CMD_CHARGE_DONE;
    send_item(it);
    it = noise_item();
    it.command      = CMD_READ;
    it.accumulator  = '0;
    it.sample_count = '0;
    send_item(it);
  endtask

  // undefined commands answer ok and must not touch the state
  task automatic test_reserved_commands();
    gauge_cmd_t it;
    it = noise_item();
    it.command = CMD_RSVD_6;
    send_item(it);
    it = noise_item();
    it.command = CMD_RSVD_7;
    send_item(it);
    it = noise_item();
    it.command      = CMD_READ;
    it.accumulator  = '0;
    it.sample_count = '0;
    send_item(it);
  endtask

  // random traffic over several register settings, the last phase without idling
  task automatic test_random_traffic();
    gauge_cmd_t it;
    // load the rest of the table so every scan sees written entries
    for (int k = 0; k < GAUGE_DEPTH; k++) begin
      if (!gauge_tbl_loaded[k]) begin
        it = noise_item();
        it.command     = CMD_TABLE_WRITE;
        it.table_index = 4'(k);
        send_item(it);
      end
    end
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      case (ph)
        0: apply_config(16'd2000, 10'd100, 5'd16);
        // zero capacity and an entry count past the table depth
        1: apply_config(16'd0, 10'd1023, 5'd31);
        2: apply_config(16'd65535, 10'd0, 5'd0);
        3: apply_config(16'd1, 10'($urandom), 5'd1);
        default: apply_config(16'($urandom_range(1, 65535)), 10'($urandom),
                              5'($urandom_range(0, 16)));
      endcase
      idle_en = (ph != NUM_PHASES - 1);
      for (int n = 0; n < PHASE_ITEMS; n++) send_item(random_item());
    end
  endtask

  initial begin
    for (int k = 0; k < GAUGE_DEPTH; k++) gauge_tbl_loaded[k] = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_table_load();
    test_init_scan();
    test_offset_read();
    test_recal_charge();
    test_reserved_commands();
    test_random_traffic();
    drain();
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

// File: files.f
rtl/ccfg_pkg.sv
rtl/ccfg_mul.sv
rtl/ccfg_div.sv
rtl/ccfg_tbl.sv
rtl/coulomb_counter_fuel_gauge_core.sv
test/tb_coulomb_counter_fuel_gauge_core.sv
